[rtl/deskewed_polygon_bounding_box_macros.svh]
// Assertion macros shared by the deskewed polygon bounding box RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DESKEWED_POLYGON_BOUNDING_BOX_MACROS_SVH
`define DESKEWED_POLYGON_BOUNDING_BOX_MACROS_SVH
`ifndef SYNTHESIS
`define DPBB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DPBB_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPBB_ASSERT(label, clk, rst, prop, msg)
`define DPBB_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[rtl/dpbb_pkg.sv]
// Package for the deskewed polygon bounding box: widths, controller states,
// command/status structs and shear arithmetic helpers. No dependencies.
package dpbb_pkg;

  localparam int COORD_W     = 16;
  localparam int SKEW_W      = 13;
  localparam int BOX_W       = 18;
  localparam int SHEAR_SHIFT = 11;
  localparam int SHEAR_ROUND = (1 << SHEAR_SHIFT) - 1;
  localparam int PROD_W      = BOX_W + SKEW_W;
  localparam int QUOT_W      = PROD_W - SHEAR_SHIFT;
  localparam int SUM_W       = QUOT_W + 1;
  localparam int IN_DATA_W   = 2 * COORD_W;
  localparam int OUT_DATA_W  = 4 * BOX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_Y,
    ST_SHEAR_Y,
    ST_MUL_X,
    ST_SHEAR_X,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_y;
    logic shear_y;
    logic mul_x;
    logic shear_x;
    logic update;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

  // Divide by 2048 truncating toward zero.
  function automatic logic signed [QUOT_W-1:0] trunc_shear(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] adj;
    if (p[PROD_W-1]) begin
      adj = p + PROD_W'(SHEAR_ROUND);
    end else begin
      adj = p;
    end
    return QUOT_W'(adj >>> SHEAR_SHIFT);
  endfunction

  // Clamp to the signed box coordinate range.
  function automatic logic signed [BOX_W-1:0] sat_box(
    input logic signed [SUM_W-1:0] v
  );
    logic [SUM_W-BOX_W:0] top_bits;
    top_bits = v[SUM_W-1:BOX_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      return v[BOX_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(BOX_W-1){1'b0}}};
    end else begin
      return {1'b0, {(BOX_W-1){1'b1}}};
    end
  endfunction

endpackage

[rtl/deskewed_polygon_bounding_box.sv]
// Deskewed polygon bounding box top level.
// Channels: s_axis takes one polygon corner per beat, tdata = {corner_y, corner_x}
// (corner_x in the low 16 bits), tlast marks the final corner of a polygon.
// m_axis gives one box per polygon, tdata = {height, width, top, left}, 18 bits
// each, left in the lowest bits. skew_we/skew_wdata write the 13-bit signed skew.
// Each corner goes through one shared 18x13 multiplier twice (y shear, then x
// shear), each multiply followed by a clamp step, then an update step sets the
// bounds. A new corner is accepted only once the last one is through its steps;
// on the last corner an emit step follows, and the box turns valid on m_axis
// in the same cycle as the block turns ready again.
// Reset clears the skew to zero, drops any pending box and starts a new polygon.
// A box waits in the output register while m_axis_tready is low; corners of the
// next polygon are still accepted and worked, and the next box holds in its
// emit step until the previous one is taken.
// Depends on dpbb_pkg, dpbb_ctrl and dpbb_datapath.
module deskewed_polygon_bounding_box (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             skew_we,
  input  logic [dpbb_pkg::SKEW_W-1:0]      skew_wdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [dpbb_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // corner_x, corner_y
  input  logic                             s_axis_tlast,   // last_corner
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [dpbb_pkg::OUT_DATA_W-1:0]  m_axis_tdata    // left, top, width, height
);
  import dpbb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dpbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  dpbb_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .skew_we    (skew_we),
    .skew_wdata (skew_wdata),
    .in_data    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .cmd        (cmd),
    .status     (status),
    .out_data   (m_axis_tdata)
  );

endmodule

[rtl/dpbb_datapath.sv]
// Datapath: skew register, shared shear multiplier, running bounds and
// result register. Depends on dpbb_pkg; driven by dpbb_ctrl commands.
module dpbb_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             skew_we,
  input  logic [dpbb_pkg::SKEW_W-1:0]      skew_wdata,
  input  logic [dpbb_pkg::IN_DATA_W-1:0]   in_data,
  input  logic                             in_last,
  input  dpbb_pkg::dp_cmd_t                cmd,
  output dpbb_pkg::dp_status_t             status,
  output logic [dpbb_pkg::OUT_DATA_W-1:0]  out_data
);
  import dpbb_pkg::*;

  logic signed [SKEW_W-1:0]  skew;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;
  logic                      last_r;
  logic signed [PROD_W-1:0]  prod;
  logic signed [BOX_W-1:0]   yd;
  logic signed [BOX_W-1:0]   xd;
  logic signed [BOX_W-1:0]   min_x;
  logic signed [BOX_W-1:0]   min_y;
  logic signed [BOX_W-1:0]   max_x;
  logic signed [BOX_W-1:0]   max_y;
  logic                      first_pending;
  logic signed [BOX_W-1:0]   res_left;
  logic signed [BOX_W-1:0]   res_top;
  logic [BOX_W-1:0]          res_width;
  logic [BOX_W-1:0]          res_height;

  logic signed [BOX_W-1:0]   mul_a;
  logic signed [QUOT_W-1:0]  quot;
  logic signed [SUM_W-1:0]   yd_sum;
  logic signed [SUM_W-1:0]   xd_sum;

  assign mul_a  = cmd.mul_y ? BOX_W'(x_r) : yd;
  assign quot   = trunc_shear(prod);
  assign yd_sum = SUM_W'(y_r) - SUM_W'(quot);
  assign xd_sum = SUM_W'(x_r) + SUM_W'(quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      skew <= '0;
    end else if (skew_we) begin
      skew <= skew_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= in_data[COORD_W-1:0];
      y_r    <= in_data[IN_DATA_W-1:COORD_W];
      last_r <= in_last;
    end
    if (cmd.mul_y || cmd.mul_x) begin
      prod <= mul_a * skew;
    end
    if (cmd.shear_y) begin
      yd <= sat_box(yd_sum);
    end
    if (cmd.shear_x) begin
      xd <= sat_box(xd_sum);
    end
    if (cmd.emit) begin
      res_left   <= min_x;
      res_top    <= min_y;
      res_width  <= max_x - min_x;
      res_height <= max_y - min_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x         <= '0;
      min_y         <= '0;
      max_x         <= '0;
      max_y         <= '0;
      first_pending <= 1'b1;
    end else if (cmd.emit) begin
      min_x         <= '0;
      min_y         <= '0;
      max_x         <= '0;
      max_y         <= '0;
      first_pending <= 1'b1;
    end else if (cmd.update) begin
      first_pending <= 1'b0;
      if (first_pending || xd < min_x) min_x <= xd;
      if (first_pending || yd < min_y) min_y <= yd;
      if (first_pending || xd > max_x) max_x <= xd;
      if (first_pending || yd > max_y) max_y <= yd;
    end
  end

  assign status.last = last_r;
  assign out_data    = {res_height, res_width, res_top, res_left};

endmodule

[rtl/dpbb_ctrl.sv]
// Controller: sequences one corner through the shared multiplier and
// holds the result valid flag. Depends on dpbb_pkg and the macros header.
`include "deskewed_polygon_bounding_box_macros.svh"
module dpbb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  dpbb_pkg::dp_status_t  status,
  output dpbb_pkg::dp_cmd_t     cmd
);
  import dpbb_pkg::*;

  state_t state;
  state_t state_next;
  logic   emit_go;

  assign emit_go = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_MUL_Y;
      ST_MUL_Y:   state_next = ST_SHEAR_Y;
      ST_SHEAR_Y: state_next = ST_MUL_X;
      ST_MUL_X:   state_next = ST_SHEAR_X;
      ST_SHEAR_X: state_next = ST_UPDATE;
      ST_UPDATE:  state_next = status.last ? ST_EMIT : ST_IDLE;
      ST_EMIT:    if (emit_go) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL_Y:   cmd.mul_y   = 1'b1;
      ST_SHEAR_Y: cmd.shear_y = 1'b1;
      ST_MUL_X:   cmd.mul_x   = 1'b1;
      ST_SHEAR_X: cmd.shear_x = 1'b1;
      ST_UPDATE:  cmd.update  = 1'b1;
      ST_EMIT:    cmd.emit    = emit_go;
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `DPBB_ASSERT_RST(a_reset_idle, clk, rst |=> (state == ST_IDLE && !out_valid), "reset must idle the controller")
  `DPBB_ASSERT(a_accept_starts, clk, rst, (in_valid && in_ready) |=> (state == ST_MUL_Y), "accepted beat must start the shear")
  `DPBB_ASSERT(a_hold_pending, clk, rst, (state == ST_EMIT && out_valid && !out_ready) |=> (state == ST_EMIT && out_valid), "pending result overwritten")
  `DPBB_ASSERT(a_valid_from_emit, clk, rst, $rose(out_valid) |-> ($past(state) == ST_EMIT), "result raised outside emit")
  `DPBB_ASSERT(a_non_last_returns, clk, rst, (state == ST_UPDATE && !status.last) |=> (state == ST_IDLE && !cmd.emit), "non-last corner must not emit")

endmodule
